@@ rtl/matrix4_column_append_defines.svh @@
// Assertion macros used by the matrix4_column_append checker.
`ifndef MATRIX4_COLUMN_APPEND_DEFINES_SVH
`define MATRIX4_COLUMN_APPEND_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define M4CA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define M4CA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/m4ca_pkg.sv @@
// Types and constants for the 4x4 column-append matrix engine.
`default_nettype none
package m4ca_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 66;
  localparam int unsigned FRAC_W = 16;

  localparam logic signed [ELEM_W-1:0] Q_ONE    = 32'sh0001_0000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

  localparam logic [1:0] COL_T = 2'd3;

  typedef enum logic [1:0] {
    OP_IDENTITY  = 2'd0,
    OP_LOAD      = 2'd1,
    OP_APPEND    = 2'd2,
    OP_TRANSLATE = 2'd3
  } op_t;

  typedef logic [3:0][ELEM_W-1:0] column_t;

  // Queued item with its classification.
  typedef struct packed {
    op_t        opcode;
    logic [1:0] column;
    column_t    elems;
    logic       mult;
    logic       writes_mat;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/m4ca_if.sv @@
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface m4ca_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [1:0]         column;
  logic signed [31:0] elem_x;
  logic signed [31:0] elem_y;
  logic signed [31:0] elem_z;
  logic signed [31:0] elem_w;

  modport source (output valid, opcode, column, elem_x, elem_y, elem_z, elem_w,
                  input ready);
  modport sink (input valid, opcode, column, elem_x, elem_y, elem_z, elem_w,
                output ready);
endinterface

interface m4ca_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_column;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               saturated;

  modport source (output valid, out_column, out_x, out_y, out_z, out_w, saturated,
                  input ready);
  modport sink (input valid, out_column, out_x, out_y, out_z, out_w, saturated,
                output ready);
endinterface
`default_nettype wire

@@ rtl/matrix4_column_append.sv @@
// Top level of the 4x4 Q16.16 column-append matrix engine.
// Path from input accept to result valid: queue, product register, result register.
// Throughput: one item per cycle unless the output stalls; an append or translate waits
// behind a matrix writer; the 16 multipliers read the committed matrix.
// Reset: matrix returns to identity, queue and pipeline empty; staged columns unset.
`default_nettype none
module matrix4_column_append import m4ca_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  m4ca_in_if.sink    in_ch,
  m4ca_out_if.source out_ch
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  m4ca_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  m4ca_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/m4ca_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module m4ca_front import m4ca_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  m4ca_in_if.sink   in_ch,
  output logic      q_valid,
  output item_t     q_item,
  input  wire logic q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             fifo [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  item_t             item_in;
  logic              push;

  always_comb begin
    item_in.opcode = op_t'(in_ch.opcode);
    item_in.column = in_ch.column;
    item_in.elems  = {in_ch.elem_w, in_ch.elem_z, in_ch.elem_y, in_ch.elem_x};
    unique case (item_in.opcode) inside
      OP_IDENTITY, OP_LOAD: begin
        item_in.mult       = 1'b0;
        item_in.writes_mat = 1'b1;
      end
      OP_APPEND: begin
        item_in.mult       = 1'b1;
        item_in.writes_mat = (in_ch.column == COL_T);
      end
      OP_TRANSLATE: begin
        item_in.mult       = 1'b1;
        item_in.writes_mat = 1'b1;
      end
      default: begin
        item_in.mult       = 1'b1;
        item_in.writes_mat = 1'b1;
      end
    endcase
  end

  assign in_ch.ready = (count != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign q_item      = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/m4ca_back.sv @@
// Back end: product stage, round/saturate and matrix update, result register.
`default_nettype none
module m4ca_back import m4ca_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  m4ca_out_if.source out_ch
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

  // Matrix is indexed [column][row].
  logic signed [ELEM_W-1:0] mat    [4][4];
  logic signed [ELEM_W-1:0] staged [3][4];

  logic signed [ELEM_W-1:0] vec [4];

  logic                     p_valid;
  item_t                    p_item;
  logic signed [PROD_W-1:0] p_prod [4][4];  // [row][column]

  logic                     p_load;
  logic                     hazard;
  logic                     adv_out;

  logic signed [ACC_W-1:0]        acc     [4];
  logic        [ACC_W-FRAC_W-1:0] shifted [4];
  logic signed [ELEM_W-1:0]       prod_col [4];
  logic                           prod_clip;

  logic signed [ELEM_W-1:0] res [4];
  logic                     res_clip;

  logic                     out_valid;
  logic [1:0]               out_column;
  logic signed [ELEM_W-1:0] out_col [4];
  logic                     out_sat;

  // Multiply stage reads the matrix, so it waits while a matrix writer drains.
  assign adv_out = p_valid && (!out_valid || out_ch.ready);
  assign p_load  = !p_valid || adv_out;
  assign hazard  = q_item.mult && p_valid && p_item.writes_mat;
  assign q_pop   = q_valid && p_load && !hazard;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vec[i] = q_item.elems[i];
    end
    if (q_item.opcode == OP_TRANSLATE) begin
      vec[2] = '0;
      vec[3] = Q_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_item <= q_item;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          p_prod[r][c] <= PROD_W'(mat[c][r]) * PROD_W'(vec[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load) begin
      p_valid <= q_pop;
    end
  end

  // Sum of four Q32.32 products, round half up to Q16.16, saturate.
  always_comb begin
    prod_clip = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc[r] = ACC_W'(p_prod[r][0]) + ACC_W'(p_prod[r][1]) +
               ACC_W'(p_prod[r][2]) + ACC_W'(p_prod[r][3]) + ROUND_HALF;
      shifted[r] = acc[r][ACC_W-1:FRAC_W];
      if ((&shifted[r][ACC_W-FRAC_W-1:ELEM_W-1]) ||
          !(|shifted[r][ACC_W-FRAC_W-1:ELEM_W-1])) begin
        prod_col[r] = shifted[r][ELEM_W-1:0];
      end else begin
        prod_col[r] = shifted[r][ACC_W-FRAC_W-1] ? ELEM_MIN : ELEM_MAX;
        prod_clip   = 1'b1;
      end
    end
  end

  always_comb begin
    res_clip = 1'b0;
    for (int r = 0; r < 4; r++) begin
      res[r] = prod_col[r];
    end
    unique case (p_item.opcode)
      OP_IDENTITY: begin
        for (int r = 0; r < 4; r++) begin
          res[r] = (2'(r) == p_item.column) ? Q_ONE : '0;
        end
      end
      OP_LOAD: begin
        for (int r = 0; r < 4; r++) begin
          res[r] = p_item.elems[r];
        end
      end
      OP_APPEND: begin
        res_clip = prod_clip;
      end
      OP_TRANSLATE: begin
        if (p_item.column == COL_T) begin
          res_clip = prod_clip;
        end else begin
          for (int r = 0; r < 4; r++) begin
            res[r] = mat[p_item.column][r];
          end
        end
      end
      default: begin
        res_clip = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          mat[c][r] <= (c == r) ? Q_ONE : '0;
        end
      end
    end else if (adv_out) begin
      unique case (p_item.opcode)
        OP_IDENTITY: begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              mat[c][r] <= (c == r) ? Q_ONE : '0;
            end
          end
        end
        OP_LOAD: begin
          for (int r = 0; r < 4; r++) begin
            mat[p_item.column][r] <= p_item.elems[r];
          end
        end
        OP_APPEND: begin
          if (p_item.column == COL_T) begin
            for (int r = 0; r < 4; r++) begin
              for (int c = 0; c < 3; c++) begin
                mat[c][r] <= staged[c][r];
              end
              mat[3][r] <= prod_col[r];
            end
          end
        end
        OP_TRANSLATE: begin
          for (int r = 0; r < 4; r++) begin
            mat[3][r] <= prod_col[r];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && p_item.opcode == OP_APPEND && p_item.column != COL_T) begin
      for (int r = 0; r < 4; r++) begin
        staged[p_item.column[1:0]][r] <= prod_col[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_column <= p_item.column;
      out_sat    <= res_clip;
      for (int r = 0; r < 4; r++) begin
        out_col[r] <= res[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_column = out_column;
  assign out_ch.out_x      = out_col[0];
  assign out_ch.out_y      = out_col[1];
  assign out_ch.out_z      = out_col[2];
  assign out_ch.out_w      = out_col[3];
  assign out_ch.saturated  = out_sat;

endmodule
`default_nettype wire

@@ rtl/m4ca_checker.sv @@
// Port-level checker for matrix4_column_append and its bind.
`default_nettype none
`include "matrix4_column_append_defines.svh"
module m4ca_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_column,
  input wire logic signed [31:0] out_x,
  input wire logic signed [31:0] out_y,
  input wire logic signed [31:0] out_z,
  input wire logic signed [31:0] out_w,
  input wire logic               saturated
);

  `M4CA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")

  `M4CA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({out_column, out_x, out_y, out_z, out_w, saturated}), "stalled result item changed")

  `M4CA_ASSERT_IMPL(a_sat_clipped, out_valid && saturated, out_x == 32'sh7fff_ffff || out_x == 32'sh8000_0000 || out_y == 32'sh7fff_ffff || out_y == 32'sh8000_0000 || out_z == 32'sh7fff_ffff || out_z == 32'sh8000_0000 || out_w == 32'sh7fff_ffff || out_w == 32'sh8000_0000, "saturated flag without a clipped element")

  `M4CA_ASSERT_IMPL(a_reset_empty, $past(rst), in_ready && !out_valid, "block not empty after reset")

endmodule

bind matrix4_column_append m4ca_checker u_m4ca_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_column (out_ch.out_column),
  .out_x      (out_ch.out_x),
  .out_y      (out_ch.out_y),
  .out_z      (out_ch.out_z),
  .out_w      (out_ch.out_w),
  .saturated  (out_ch.saturated)
);
`default_nettype wire
